// ----- hdl/i2c_bseq_pkg.sv -----
// Package for the I2C master bit sequencer: opcodes, widths and command lengths.
package i2c_bseq_pkg;

    localparam int BYTE_BITS = 8;
    localparam int SLOT_W    = 5;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_SACK  = 3'd5,
        OP_RACK  = 3'd6
    } opcode_t;

    // Index of the final slot of each command
    function automatic logic [SLOT_W-1:0] cmd_last_slot(input opcode_t cmd);
        logic [SLOT_W-1:0] r;
        case (cmd)
            OP_START: r = SLOT_W'(3);
            OP_STOP:  r = SLOT_W'(2);
            OP_WRITE: r = SLOT_W'(3 * BYTE_BITS - 1);
            OP_READ:  r = SLOT_W'(3 * BYTE_BITS);
            OP_SACK:  r = SLOT_W'(2);
            OP_RACK:  r = SLOT_W'(3);
            default:  r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/i2c_master_bit_sequencer_unit.sv -----
// I2C master bit sequencer: one timing slot per input transfer, one result per slot.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: opcode, tx_byte, ack_out, sda_in
//  m_      | out | m_tvalid/m_tready  | m_tdata: scl, sda, busy, rx_byte, ack_in; m_tlast: done
//
// The result of a slot is registered and appears in the cycle after its input transfer.
// Sequencer state and the result register update together in the accepting cycle.
// The input is taken whenever the result register is empty or being emptied,
// so a full throughput of one slot per cycle is held while m_tready stays high.
// Reset releases both lines and leaves the sequencer idle with no result pending.
module i2c_master_bit_sequencer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [2:0] opcode, [10:3] tx_byte, [11] ack_out, [12] sda_in, [15:13] zero
    input  logic [i2c_bseq_pkg::IN_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] scl_level, [1] sda_level, [2] busy_res, [10:3] rx_byte, [11] ack_in, [15:12] zero
    output logic [i2c_bseq_pkg::OUT_W-1:0] m_tdata,
    // done_res: last slot of the command
    output logic                           m_tlast
);
    import i2c_bseq_pkg::*;

    // input fields
    logic [2:0]           in_op;
    logic [BYTE_BITS-1:0] in_tx;
    logic                 in_ack;
    logic                 in_sda;
    logic                 accept;

    assign in_op  = s_tdata[2:0];
    assign in_tx  = s_tdata[3 +: BYTE_BITS];
    assign in_ack = s_tdata[3 + BYTE_BITS];
    assign in_sda = s_tdata[4 + BYTE_BITS];

    // sequencer state
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;
    opcode_t              cmd_reg, cmd_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [1:0]           phase_reg, phase_next;
    logic [BYTE_BITS-1:0] shout_reg, shout_next;
    logic [BYTE_BITS-1:0] shin_reg, shin_next;
    logic                 ack_reg, ack_next;

    // result register
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg, out_data_next;
    logic                 out_last_reg, out_last_next;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // one slot of work
    always_comb begin
        logic                 start;
        logic                 busy;
        logic                 last;
        opcode_t              cmd;
        logic [SLOT_W-1:0]    slot;
        logic [1:0]           phase;
        logic [BYTE_BITS-1:0] shout;
        logic [1:0]           phase_inc;

        start = (cmd_reg == OP_NONE) && (in_op >= 3'(OP_START)) && (in_op <= 3'(OP_RACK));
        cmd   = start ? opcode_t'(in_op) : cmd_reg;
        slot  = start ? '0 : slot_reg;
        phase = start ? 2'd0 : phase_reg;
        shout = (start && (in_op == 3'(OP_WRITE))) ? in_tx : shout_reg;
        busy  = (cmd != OP_NONE);
        last  = busy && (slot == cmd_last_slot(cmd));
        phase_inc = (phase == 2'd2) ? 2'd0 : phase + 2'd1;

        scl_next   = scl_reg;
        sda_next   = sda_reg;
        shout_next = shout;
        shin_next  = shin_reg;
        ack_next   = ack_reg;
        phase_next = phase;

        case (cmd)
            OP_START: begin
                case (slot[1:0])
                    2'd0:    sda_next = 1'b1;
                    2'd1:    scl_next = 1'b1;
                    2'd2:    sda_next = 1'b0;
                    default: scl_next = 1'b0;
                endcase
            end
            OP_STOP: begin
                case (slot[1:0])
                    2'd0:    sda_next = 1'b0;
                    2'd1:    scl_next = 1'b1;
                    default: sda_next = 1'b1;
                endcase
            end
            OP_WRITE: begin
                // data bit, clock high, clock low; MSB leaves first
                case (phase)
                    2'd0: begin
                        sda_next   = shout[BYTE_BITS-1];
                        shout_next = {shout[BYTE_BITS-2:0], 1'b0};
                    end
                    2'd1:    scl_next = 1'b1;
                    default: scl_next = 1'b0;
                endcase
                phase_next = phase_inc;
            end
            OP_READ: begin
                if (slot == '0) begin
                    sda_next = 1'b1;
                end else begin
                    case (phase)
                        2'd0:    scl_next  = 1'b1;
                        2'd1:    shin_next = {shin_reg[BYTE_BITS-2:0], in_sda};
                        default: scl_next  = 1'b0;
                    endcase
                    phase_next = phase_inc;
                end
            end
            OP_SACK: begin
                case (slot[1:0])
                    2'd0:    sda_next = in_ack;
                    2'd1:    scl_next = 1'b1;
                    default: scl_next = 1'b0;
                endcase
            end
            OP_RACK: begin
                case (slot[1:0])
                    2'd0:    sda_next = 1'b1;
                    2'd1:    scl_next = 1'b1;
                    2'd2:    ack_next = in_sda;
                    default: scl_next = 1'b0;
                endcase
            end
            default: ;
        endcase

        if (!busy || last) begin
            cmd_next   = OP_NONE;
            slot_next  = '0;
            phase_next = 2'd0;
        end else begin
            cmd_next  = cmd;
            slot_next = slot + SLOT_W'(1);
        end

        out_data_next = '0;
        out_data_next[0] = scl_next;
        out_data_next[1] = sda_next;
        out_data_next[2] = busy;
        out_data_next[3 +: BYTE_BITS] = shin_next;
        out_data_next[3 + BYTE_BITS]  = ack_next;
        out_last_next = last;
    end

    // state and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            cmd_reg       <= OP_NONE;
            slot_reg      <= '0;
            phase_reg     <= 2'd0;
            shout_reg     <= '0;
            shin_reg      <= '0;
            ack_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                scl_reg      <= scl_next;
                sda_reg      <= sda_next;
                cmd_reg      <= cmd_next;
                slot_reg     <= slot_next;
                phase_reg    <= phase_next;
                shout_reg    <= shout_next;
                shin_reg     <= shin_next;
                ack_reg      <= ack_next;
                out_data_reg <= out_data_next;
                out_last_reg <= out_last_next;
            end
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // a final slot is always a busy slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tdata[2])
        else $error("done without busy");

    // idle sequencer keeps its slot counter cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_reg == OP_NONE) |-> (slot_reg == '0 && phase_reg == 2'd0))
        else $error("idle with slot count set");

    // slot counter never runs past the end of the command
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_reg != OP_NONE) |-> (slot_reg <= cmd_last_slot(cmd_reg)))
        else $error("slot count overrun");

    // without an input transfer the sequencer state does not move
    assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> ($stable(cmd_reg) && $stable(slot_reg) && $stable(shin_reg)))
        else $error("state moved without transfer");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the I2C master bit sequencer: slot predictor and stream checks.
module tb;
    import i2c_bseq_pkg::*;

    localparam logic [2:0] OP_UNUSED = 3'd7;   // spare opcode, must be ignored
    localparam int RANDOM_ITEMS = 700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;

    // One timing slot as offered on the input channel
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] tx;
        logic       ack_out;
        logic       sda_in;
    } slot_t;

    // One result as seen on the output channel
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       ack;
    } slot_res_t;

    typedef struct packed {
        slot_t     it;
        logic      typed;
        slot_res_t want;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tlast;

    i2c_master_bit_sequencer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Predictor state: pin drives, running command and shift registers
    logic        bus_scl = 1'b1;
    logic        bus_sda = 1'b1;
    opcode_t     bus_cmd = OP_NONE;
    int          bus_slot = 0;
    logic [7:0]  tx_shift = '0;
    logic [7:0]  rx_shift = '0;
    logic        ack_seen = 1'b0;

    slot_res_t   pending_slots[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          hold_req = 0;
    bit          tx_calm = 0;

    // Directed slots: idle, spare opcode, START, STOP, SACK and RACK, commands offered while busy
    dir_row_t directed_rows [23] = '{
        '{'{OP_NONE,   8'h00, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{'{OP_UNUSED, 8'hFF, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{'{OP_START,  8'h00, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{'{OP_READ,   8'hFF, 1'b1, 1'b1}, 1'b0, '0},
        '{'{OP_NONE,   8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_NONE,   8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_RACK,   8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_NONE,   8'h00, 1'b0, 1'b1}, 1'b0, '0},
        '{'{OP_NONE,   8'h00, 1'b0, 1'b1}, 1'b0, '0},
        '{'{OP_NONE,   8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_SACK,   8'hFF, 1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_STOP,   8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_NONE,   8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_SACK,   8'h00, 1'b0, 1'b1}, 1'b0, '0},
        '{'{OP_NONE,   8'h00, 1'b1, 1'b0}, 1'b0, '0},
        '{'{OP_NONE,   8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_STOP,   8'h80, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_NONE,   8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_NONE,   8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_RACK,   8'h01, 1'b0, 1'b1}, 1'b0, '0},
        '{'{OP_NONE,   8'h00, 1'b0, 1'b1}, 1'b0, '0},
        '{'{OP_NONE,   8'h00, 1'b0, 1'b0}, 1'b0, '0},
        '{'{OP_NONE,   8'h00, 1'b0, 1'b0}, 1'b0, '0}
    };

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic int slot_total(input opcode_t c);
        case (c)
            OP_START, OP_RACK: return 4;
            OP_STOP, OP_SACK:  return 3;
            OP_WRITE:          return 3 * BYTE_BITS;
            OP_READ:           return 3 * BYTE_BITS + 1;
            default:           return 1;
        endcase
    endfunction

    // Gap length for either side: mostly none, some short, a few long
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the sequencer by one slot and return the expected result
    function automatic slot_res_t step_sequencer(input slot_t it);
        slot_res_t r;
        int        ph;
        r = '0;
        if (bus_cmd == OP_NONE && it.op >= OP_START && it.op <= OP_RACK) begin
            bus_cmd  = opcode_t'(it.op);
            bus_slot = 0;
            if (bus_cmd == OP_WRITE) tx_shift = it.tx;
        end
        if (bus_cmd != OP_NONE) begin
            r.busy = 1'b1;
            case (bus_cmd)
                OP_START: begin
                    case (bus_slot)
                        0:       bus_sda = 1'b1;
                        1:       bus_scl = 1'b1;
                        2:       bus_sda = 1'b0;
                        default: bus_scl = 1'b0;
                    endcase
                end
                OP_STOP: begin
                    case (bus_slot)
                        0:       bus_sda = 1'b0;
                        1:       bus_scl = 1'b1;
                        default: bus_sda = 1'b1;
                    endcase
                end
                OP_WRITE: begin
                    ph = bus_slot % 3;
                    if (ph == 0) bus_sda = tx_shift[BYTE_BITS - 1 - bus_slot / 3];
                    else if (ph == 1) bus_scl = 1'b1;
                    else bus_scl = 1'b0;
                end
                OP_READ: begin
                    if (bus_slot == 0) begin
                        bus_sda = 1'b1;
                    end else begin
                        ph = (bus_slot - 1) % 3;
                        if (ph == 0) bus_scl = 1'b1;
                        else if (ph == 1) rx_shift = {rx_shift[6:0], it.sda_in};
                        else bus_scl = 1'b0;
                    end
                end
                OP_SACK: begin
                    case (bus_slot)
                        0:       bus_sda = it.ack_out;
                        1:       bus_scl = 1'b1;
                        default: bus_scl = 1'b0;
                    endcase
                end
                OP_RACK: begin
                    case (bus_slot)
                        0:       bus_sda = 1'b1;
                        1:       bus_scl = 1'b1;
                        2:       ack_seen = it.sda_in;
                        default: bus_scl = 1'b0;
                    endcase
                end
                default: ;
            endcase
            if (bus_slot + 1 >= slot_total(bus_cmd)) begin
                r.done   = 1'b1;
                bus_cmd  = OP_NONE;
                bus_slot = 0;
            end else begin
                bus_slot++;
            end
        end
        r.scl = bus_scl;
        r.sda = bus_sda;
        r.rx  = rx_shift;
        r.ack = ack_seen;
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        mismatches++;
    endtask

    task automatic check_slot_result();
        slot_res_t w;
        if (pending_slots.size() == 0) begin
            note_mismatch("result with no slot pending", int'(m_tdata), 0);
            return;
        end
        w = pending_slots.pop_front();
        if (m_tdata[0] !== w.scl)
            note_mismatch("scl_level", int'(m_tdata[0]), int'(w.scl));
        if (m_tdata[1] !== w.sda)
            note_mismatch("sda_level", int'(m_tdata[1]), int'(w.sda));
        if (m_tdata[2] !== w.busy)
            note_mismatch("busy_res", int'(m_tdata[2]), int'(w.busy));
        if (m_tlast !== w.done)
            note_mismatch("done_res", int'(m_tlast), int'(w.done));
        if (m_tdata[10:3] !== w.rx)
            note_mismatch("rx_byte", int'(m_tdata[10:3]), int'(w.rx));
        if (m_tdata[11] !== w.ack)
            note_mismatch("ack_in", int'(m_tdata[11]), int'(w.ack));
    endtask

    // Offer one slot, wait for the transfer, record what should come back
    task automatic offer_slot(input slot_t it, input logic typed, input slot_res_t want);
        slot_res_t p;
        int        gap;
        s_tdata  <= {3'b000, it.sda_in, it.ack_out, it.tx, it.op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        p = step_sequencer(it);
        pending_slots.push_back(typed ? want : p);
        gap = pick_gap(tx_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Result side: random back-pressure plus one long hold on request
    initial begin : result_side
        int stall;
        int hold;
        int tick;
        bit calm;
        stall = 0;
        hold  = 0;
        tick  = 0;
        calm  = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) check_slot_result();
            tick++;
            if (tick % 200 == 0) calm = ($urandom_range(0, 2) == 0);
            if (hold_req) begin
                hold     = HOLD_CYCLES;
                hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall = pick_gap(calm);
            end
        end
    end

    // Input side: reset, directed table, then command sequences
    initial begin : slot_source
        slot_t it;
        int    r;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            offer_slot(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) tx_calm = ($urandom_range(0, 2) == 0);
            // one pause until the block has drained completely
            if (n == 250) begin
                s_tvalid <= 1'b0;
                while (pending_slots.size() != 0) @(posedge aclk);
            end
            if (n == 450) hold_req = 1;

            it.ack_out = 1'($urandom_range(0, 1));
            it.sda_in  = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 99);
            if (r < 15) begin
                case ($urandom_range(0, 3))
                    0:       it.tx = 8'h00;
                    1:       it.tx = 8'hFF;
                    2:       it.tx = 8'h80;
                    default: it.tx = 8'h01;
                endcase
            end else begin
                it.tx = 8'($urandom_range(0, 255));
            end
            if (bus_cmd == OP_NONE) begin
                // mostly a fresh command, sometimes an idle or spare opcode
                r = $urandom_range(0, 99);
                if (r < 5)       it.op = OP_NONE;
                else if (r < 10) it.op = OP_UNUSED;
                else             it.op = 3'($urandom_range(OP_START, OP_RACK));
            end else begin
                // mid-command: occasionally try to start another one
                it.op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : OP_NONE;
            end
            offer_slot(it, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_slots.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
